/* design/pdcs_pkg.sv */
// ----------------------------------------------------------------------------
// pdcs_pkg
// Shared types and constants of the pulse-distance command sender.
// ----------------------------------------------------------------------------
package pdcs_pkg;

  // Transmit sequencer phases, one-hot
  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_HDR_MARK  = 7'b0000010,
    PH_HDR_SPACE = 7'b0000100,
    PH_BIT_MARK  = 7'b0001000,
    PH_BIT_SPACE = 7'b0010000,
    PH_END_MARK  = 7'b0100000,
    PH_END_SPACE = 7'b1000000
  } phase_t;

  // Item class decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_REQ  = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  localparam int KIND_W     = 2;
  localparam int TICK_W     = 16;
  localparam int REP_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARK         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPACE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd5;

  // Register reset values
  localparam logic [TICK_W-1:0] RST_MARK         = 16'd2000;
  localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 16'd2000;
  localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 16'd4000;
  localparam logic [TICK_W-1:0] RST_HEADER_SPACE = 16'd6000;
  localparam logic [TICK_W-1:0] RST_END_SPACE    = 16'd8000;
  localparam logic [REP_W-1:0]  RST_REPEAT_COUNT = 4'd3;

  typedef struct packed {
    logic [TICK_W-1:0] mark;
    logic [TICK_W-1:0] one_space;
    logic [TICK_W-1:0] zero_space;
    logic [TICK_W-1:0] header_space;
    logic [TICK_W-1:0] end_space;
    logic [REP_W-1:0]  rep_count;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic refused;
  } res_t;

endpackage

/* design/pdcs_in_if.sv */
// ----------------------------------------------------------------------------
// pdcs_in_if
// Input channel: valid/ready with request type and command code.
// ----------------------------------------------------------------------------
interface pdcs_in_if #(
  parameter int CODE_BITS = 3
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [CODE_BITS-1:0] command_code;

  modport source (output valid, output req_type, output command_code, input ready);
  modport sink   (input valid, input req_type, input command_code, output ready);
endinterface

/* design/pdcs_out_if.sv */
// ----------------------------------------------------------------------------
// pdcs_out_if
// Result channel: valid/ready with line level, busy and refused flags.
// ----------------------------------------------------------------------------
interface pdcs_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic refused;

  modport source (output valid, output line_level, output busy_res, output refused,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input refused,
                  output ready);
endinterface

/* design/pdcs_front.sv */
// ----------------------------------------------------------------------------
// pdcs_front
// Accept input transfers and classify them as tick, request or bad code.
// ----------------------------------------------------------------------------
module pdcs_front #(
  parameter int CODE_BITS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pdcs_in_if.sink              in_if,
  output logic                 item_vld,
  output pdcs_pkg::kind_t      item_kind,
  output logic [CODE_BITS-1:0] item_code,
  input  logic                 item_rdy
);
  import pdcs_pkg::*;

  logic                 vld_r, vld_nxt;
  kind_t                kind_r, kind_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;
  logic                 take;

  assign in_if.ready = !vld_r || item_rdy;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    vld_nxt  = vld_r;
    kind_nxt = kind_r;
    code_nxt = code_r;
    if (take) begin
      vld_nxt  = 1'b1;
      code_nxt = in_if.command_code;
      // all-ones code is reserved
      if (in_if.req_type) begin
        kind_nxt = KIND_TICK;
      end else if (&in_if.command_code) begin
        kind_nxt = KIND_BAD;
      end else begin
        kind_nxt = KIND_REQ;
      end
    end else if (item_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    kind_r <= kind_nxt;
    code_r <= code_nxt;
  end

  assign item_vld  = vld_r;
  assign item_kind = kind_r;
  assign item_code = code_r;

endmodule

/* design/pdcs_fifo.sv */
// ----------------------------------------------------------------------------
// pdcs_fifo
// Two-entry queue between front end and transmit sequencer.
// ----------------------------------------------------------------------------
module pdcs_fifo #(
  parameter int W = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_vld,
  input  logic [W-1:0] push_data,
  output logic         push_rdy,
  output logic         pop_vld,
  output logic [W-1:0] pop_data,
  input  logic         pop_rdy
);
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_rdy = (cnt_r != CNT_W'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/pdcs_back.sv */
// ----------------------------------------------------------------------------
// pdcs_back
// Transmit sequencer: runs the frame phases on ticks and registers results.
// ----------------------------------------------------------------------------
module pdcs_back #(
  parameter int CODE_BITS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdcs_pkg::cfg_t       cfg,
  input  logic                 item_vld,
  input  pdcs_pkg::kind_t      item_kind,
  input  logic [CODE_BITS-1:0] item_code,
  output logic                 item_rdy,
  output logic                 res_vld,
  output pdcs_pkg::res_t       res,
  input  logic                 res_rdy
);
  import pdcs_pkg::*;

  localparam int BCW = $clog2(CODE_BITS + 1);

  phase_t               phase_r, phase_nxt;
  logic                 line_r, line_nxt;
  logic [BCW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [BCW-1:0]       bit_inc;
  logic [REP_W-1:0]     rep_left_r, rep_left_nxt;
  logic [TICK_W-1:0]    cnt_r, cnt_nxt;
  logic [TICK_W-1:0]    cnt_inc;
  logic [TICK_W-1:0]    seg_raw, seg_len;
  logic [CODE_BITS-1:0] code_r, code_nxt;
  logic [CODE_BITS-1:0] sh_r, sh_nxt;
  logic                 seg_done;
  logic                 refused;
  logic                 pop;
  logic                 res_vld_r, res_vld_nxt;
  res_t                 res_r, res_nxt;

  assign item_rdy = !res_vld_r || res_rdy;
  assign pop      = item_vld && item_rdy;
  assign cnt_inc  = cnt_r + 1'b1;
  assign bit_inc  = bit_cnt_r + 1'b1;

  // Segment length, read live from the registers; zero counts as one
  always_comb begin
    case (phase_r)
      PH_HDR_SPACE: seg_raw = cfg.header_space;
      PH_BIT_SPACE: seg_raw = sh_r[CODE_BITS-1] ? cfg.one_space : cfg.zero_space;
      PH_END_SPACE: seg_raw = cfg.end_space;
      default:      seg_raw = cfg.mark;
    endcase
    seg_len  = (seg_raw == '0) ? TICK_W'(1) : seg_raw;
    seg_done = (cnt_inc >= seg_len) || (cnt_inc == '0);
  end

  always_comb begin
    phase_nxt    = phase_r;
    line_nxt     = line_r;
    bit_cnt_nxt  = bit_cnt_r;
    rep_left_nxt = rep_left_r;
    cnt_nxt      = cnt_r;
    code_nxt     = code_r;
    sh_nxt       = sh_r;
    refused      = 1'b0;
    if (pop) begin
      case (item_kind)
        KIND_REQ: begin
          if (phase_r != PH_IDLE) begin
            refused = 1'b1;
          end else begin
            code_nxt     = item_code;
            rep_left_nxt = (cfg.rep_count == '0) ? REP_W'(1) : cfg.rep_count;
            bit_cnt_nxt  = '0;
            cnt_nxt      = '0;
            phase_nxt    = PH_HDR_MARK;
            line_nxt     = 1'b1;
          end
        end
        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            cnt_nxt = cnt_inc;
            if (seg_done) begin
              cnt_nxt = '0;
              unique case (phase_r)
                PH_HDR_MARK: begin
                  phase_nxt = PH_HDR_SPACE;
                  line_nxt  = 1'b0;
                end
                PH_HDR_SPACE: begin
                  // load the held code for this frame's bits
                  phase_nxt   = PH_BIT_MARK;
                  bit_cnt_nxt = '0;
                  sh_nxt      = code_r;
                  line_nxt    = 1'b1;
                end
                PH_BIT_MARK: begin
                  phase_nxt = PH_BIT_SPACE;
                  line_nxt  = 1'b0;
                end
                PH_BIT_SPACE: begin
                  // advance to the next bit, msb first
                  bit_cnt_nxt = bit_inc;
                  sh_nxt      = sh_r << 1;
                  phase_nxt   = (bit_inc == BCW'(CODE_BITS)) ? PH_END_MARK : PH_BIT_MARK;
                  line_nxt    = 1'b1;
                end
                PH_END_MARK: begin
                  phase_nxt = PH_END_SPACE;
                  line_nxt  = 1'b0;
                end
                PH_END_SPACE: begin
                  line_nxt    = 1'b1;
                  bit_cnt_nxt = '0;
                  if (rep_left_r > REP_W'(1)) begin
                    rep_left_nxt = rep_left_r - 1'b1;
                    phase_nxt    = PH_HDR_MARK;
                  end else begin
                    rep_left_nxt = '0;
                    phase_nxt    = PH_IDLE;
                  end
                end
                PH_IDLE: begin
                  phase_nxt = PH_IDLE;
                  line_nxt  = 1'b1;
                end
              endcase
            end
          end
        end
        default: begin
          refused = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    res_nxt     = res_r;
    if (pop) begin
      res_vld_nxt        = 1'b1;
      res_nxt.line_level = line_nxt;
      res_nxt.busy_res   = (phase_nxt != PH_IDLE);
      res_nxt.refused    = refused;
    end else if (res_rdy) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      line_r     <= 1'b1;
      bit_cnt_r  <= '0;
      rep_left_r <= '0;
      cnt_r      <= '0;
      code_r     <= '0;
      sh_r       <= '0;
      res_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      line_r     <= line_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      rep_left_r <= rep_left_nxt;
      cnt_r      <= cnt_nxt;
      code_r     <= code_nxt;
      sh_r       <= sh_nxt;
      res_vld_r  <= res_vld_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (line_r && cnt_r == '0 && bit_cnt_r == '0))
    else $error("idle sequencer with line low or counters running");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BCW'(CODE_BITS))
    else $error("bit counter past code width");

  a_start_only_on_req: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE && !(pop && item_kind == KIND_REQ)) |=> (phase_r == PH_IDLE))
    else $error("sequencer left idle without an accepted request");

  a_frames_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (rep_left_r != '0))
    else $error("busy with no frames left");

endmodule

/* design/pulse_distance_command_sender_top.sv */
// ----------------------------------------------------------------------------
// pulse_distance_command_sender_top
// Pulse-distance encoder for a short command, sent a set number of times.
//
//   channel  dir  handshake            payload
//   in_if    in   valid/ready          req_type, command_code[CODE_BITS-1:0]
//   out_if   out  valid/ready          line_level, busy_res, refused
//   cfg_*    in   cfg_we (no wait)     cfg_idx[2:0], cfg_data[15:0]
//
// One item per clock sustained while out_if.ready is high; each input transfer
// gives exactly one result. Items pass the classify register, the queue and
// the sequencer result register. The sequencer adds and compares once per tick.
// rst_n is synchronous, active low; registers return to their default lengths.
// Either side may stall on its own; the queue absorbs up to two items.
// ----------------------------------------------------------------------------
module pulse_distance_command_sender_top #(
  parameter int CODE_BITS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pdcs_in_if.sink                              in_if,
  pdcs_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [pdcs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pdcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pdcs_pkg::*;

  localparam int ITEM_W = KIND_W + CODE_BITS;

  // Configuration registers
  cfg_t cfg_r, cfg_nxt;

  // Front end to queue
  logic                 fe_vld, fe_rdy;
  kind_t                fe_kind;
  logic [CODE_BITS-1:0] fe_code;

  // Queue to sequencer
  logic                 q_vld, q_rdy;
  logic [ITEM_W-1:0]    q_data;

  // Sequencer result
  logic                 res_vld;
  res_t                 res;

  // Write a register; unknown indexes drop the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_MARK:         cfg_nxt.mark         = cfg_data;
        REG_ONE_SPACE:    cfg_nxt.one_space    = cfg_data;
        REG_ZERO_SPACE:   cfg_nxt.zero_space   = cfg_data;
        REG_HEADER_SPACE: cfg_nxt.header_space = cfg_data;
        REG_END_SPACE:    cfg_nxt.end_space    = cfg_data;
        REG_REPEAT_COUNT: cfg_nxt.rep_count    = cfg_data[REP_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark         <= RST_MARK;
      cfg_r.one_space    <= RST_ONE_SPACE;
      cfg_r.zero_space   <= RST_ZERO_SPACE;
      cfg_r.header_space <= RST_HEADER_SPACE;
      cfg_r.end_space    <= RST_END_SPACE;
      cfg_r.rep_count    <= RST_REPEAT_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept and classify
  pdcs_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .item_vld  (fe_vld),
    .item_kind (fe_kind),
    .item_code (fe_code),
    .item_rdy  (fe_rdy)
  );

  // Decouple classification from the sequencer
  pdcs_fifo #(
    .W (ITEM_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fe_vld),
    .push_data ({fe_kind, fe_code}),
    .push_rdy  (fe_rdy),
    .pop_vld   (q_vld),
    .pop_data  (q_data),
    .pop_rdy   (q_rdy)
  );

  // Run the frame sequence and hold each result until transferred
  pdcs_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_vld  (q_vld),
    .item_kind (kind_t'(q_data[ITEM_W-1 -: KIND_W])),
    .item_code (q_data[CODE_BITS-1:0]),
    .item_rdy  (q_rdy),
    .res_vld   (res_vld),
    .res       (res),
    .res_rdy   (out_if.ready)
  );

  assign out_if.valid      = res_vld;
  assign out_if.line_level = res.line_level;
  assign out_if.busy_res   = res.busy_res;
  assign out_if.refused    = res.refused;

endmodule
